@@ hdl/audio_rms_peak_meter_defines.svh @@
// Assertion macros shared by the level meter RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef AUDIO_RMS_PEAK_METER_DEFINES_SVH
`define AUDIO_RMS_PEAK_METER_DEFINES_SVH

// The property holds at every clock edge outside reset.
`define ARPM_ASSERT_ALWAYS(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("audio_rms_peak_meter: invariant violated");

// The consequent holds in the same cycle as the antecedent.
`define ARPM_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("audio_rms_peak_meter: same-cycle check failed");

// The consequent holds in the cycle after the antecedent.
`define ARPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("audio_rms_peak_meter: next-cycle check failed");

`endif

@@ hdl/arpm_pkg.sv @@
// Package for the level meter: beat structs, fixed widths and constants.
// Used by arpm_sqrt, the top level and the testbench; depends on nothing.
`default_nettype none

package arpm_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int PEAK_W     = 15;
  localparam int LEVEL_W    = 16;
  localparam int EPEAK_W    = 25;
  localparam int MEAN_W     = 31;
  localparam int RAD_W      = 32;
  localparam int ROOT_W     = 16;
  localparam int SQRT_STEPS = 16;
  localparam int GAIN_W     = 17;
  localparam int PROD_W     = 33;

  localparam logic [GAIN_W-1:0] VU_GAIN = 17'd117965;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       last_frame;
    logic                       restart;
  } frame_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] left_level;
    logic [LEVEL_W-1:0] right_level;
    logic [PEAK_W-1:0]  peak_sample;
    logic [EPEAK_W-1:0] energy_peak;
  } level_t;

  function automatic logic [LEVEL_W-1:0] vu_round(input logic [PROD_W-1:0] p);
    logic [PROD_W:0] s;
    s = {1'b0, p} + (PROD_W+1)'(32768);
    return s[31:16];
  endfunction

endpackage

`default_nettype wire

@@ hdl/arpm_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on nothing; used by the level meter sequencer.
`default_nettype none

module arpm_div #(
  parameter int DVD_W = 43,
  parameter int DVS_W = 13
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic      [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic [DVS_W-1:0] rem;
  logic [DVS_W:0]   shifted;
  logic             ge;

  assign shifted  = {rem, dvd[DVD_W-1]};
  assign ge       = shifted >= {1'b0, dvs};
  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= DVS_W'(ge ? shifted - {1'b0, dvs} : shifted);
      dvd <= {dvd[DVD_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

@@ hdl/arpm_sqrt.sv @@
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on arpm_pkg for the radicand and root widths.
`default_nettype none

module arpm_sqrt
  import arpm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [RAD_W-1:0]  radicand,
  output logic                   done,
  output logic      [ROOT_W-1:0] root
);

  localparam int CNT_W = $clog2(SQRT_STEPS + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [RAD_W-1:0]  rad;
  logic [ROOT_W:0]   rem;
  logic [ROOT_W+2:0] rem_s;
  logic [ROOT_W+2:0] trial;
  logic              ge;

  assign rem_s = {rem, rad[RAD_W-1:RAD_W-2]};
  assign trial = {1'b0, root, 2'b01};
  assign ge    = rem_s >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(SQRT_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rem  <= (ROOT_W+1)'(ge ? rem_s - trial : rem_s);
      root <= {root[ROOT_W-2:0], ge};
      rad  <= {rad[RAD_W-3:0], 2'b00};
    end
  end

endmodule

`default_nettype wire

@@ hdl/audio_rms_peak_meter.sv @@
// Top level of the block RMS and peak level meter: sequencer, shared multiplier, state.
// Depends on arpm_pkg, arpm_div, arpm_sqrt and audio_rms_peak_meter_defines.svh.
//
// Frames arrive on the frame channel (frame_valid, frame_stall, frame), one beat per
// frame holding the left and right samples, the last-frame mark and the restart flag.
// Results leave on the level channel (level_valid, level_stall, level), one beat for
// each frame marked last. The stereo_mode register is written over the cfg channel,
// which is always ready; it should only be changed while the meter is idle.
// A frame that does not end a block takes the meter through S_SQL, S_SQR and S_ACCR: the squares
// of both samples go one after the other through a single 16 by 17 bit multiplier.
// The last frame of a block then runs three divisions on a bit-serial divider of
// SUM_W = clog2(MAX_FRAMES) + 31 steps and two 16-step square roots.
// frame_stall is high whenever the sequencer is out of S_IDLE. The finished beat sits
// in an output register, so a stalled receiver holds up the meter only when a second
// result is ready before the first has been taken. Synchronous reset clears the sums,
// the frame count and both running peaks, drops any pending result and sets
// stereo_mode to 1.
`include "audio_rms_peak_meter_defines.svh"
`default_nettype none

module audio_rms_peak_meter
  import arpm_pkg::*;
#(
  parameter int MAX_FRAMES = 4096
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   frame_valid,
  output logic        frame_stall,
  input  wire frame_t frame,
  output logic        level_valid,
  input  wire logic   level_stall,
  output level_t      level,
  input  wire logic   cfg_valid,
  output logic        cfg_ready,
  input  wire logic   stereo_mode
);

  localparam int CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int SUM_W = $clog2(MAX_FRAMES) + 31;

  typedef enum logic [16:0] {
    S_IDLE   = 17'h00001,
    S_SQL    = 17'h00002,
    S_SQR    = 17'h00004,
    S_ACCR   = 17'h00008,
    S_DIVL   = 17'h00010,
    S_WDIVL  = 17'h00020,
    S_SQRTL  = 17'h00040,
    S_WSQRTL = 17'h00080,
    S_DIVR   = 17'h00100,
    S_WDIVR  = 17'h00200,
    S_SQRTR  = 17'h00400,
    S_WSQRTR = 17'h00800,
    S_DIVE   = 17'h01000,
    S_WDIVE  = 17'h02000,
    S_VUL    = 17'h04000,
    S_VUR    = 17'h08000,
    S_FIN    = 17'h10000
  } state_t;

  state_t state;
  state_t state_next;

  logic               stereo_sel;
  frame_t             item;
  logic               item_stereo;
  logic [SUM_W-1:0]   left_sum;
  logic [SUM_W-1:0]   right_sum;
  logic [CNT_W-1:0]   frames_seen;
  logic [PEAK_W-1:0]  running_peak;
  logic [EPEAK_W-1:0] energy_peak;
  logic [MEAN_W-1:0]  mean;
  logic [ROOT_W-1:0]  lrms;
  logic [ROOT_W-1:0]  rrms;
  logic [EPEAK_W-1:0] ep;
  logic [LEVEL_W-1:0] left_lvl;
  logic [PROD_W-1:0]  prod;

  logic               accept;
  logic               out_free;
  logic               counting;
  logic [PEAK_W-1:0]  peak_base;
  logic [PEAK_W-1:0]  peak_l;
  logic [PEAK_W-1:0]  peak_next;
  logic [SAMPLE_W-1:0] left_abs;
  logic [SAMPLE_W-1:0] right_abs;
  logic [SAMPLE_W-1:0] mul_a;
  logic [GAIN_W-1:0]  mul_b;
  logic [EPEAK_W-1:0] epeak_next;

  logic               div_start;
  logic               div_done;
  logic [SUM_W-1:0]   div_dividend;
  logic [CNT_W-1:0]   div_divisor;
  logic [SUM_W-1:0]   div_quotient;
  logic               sqrt_start;
  logic               sqrt_done;
  logic [ROOT_W-1:0]  sqrt_root;
  logic               div_waiting;
  logic               sqrt_waiting;

  assign frame_stall = (state != S_IDLE);
  assign accept      = frame_valid && !frame_stall;
  assign cfg_ready   = 1'b1;
  assign out_free    = !level_valid || !level_stall;
  assign counting    = frames_seen < CNT_W'(MAX_FRAMES);

  assign peak_base = frame.restart ? '0 : running_peak;
  assign peak_l    = (!frame.left_sample[SAMPLE_W-1] &&
                      frame.left_sample[PEAK_W-1:0] > peak_base) ?
                     frame.left_sample[PEAK_W-1:0] : peak_base;
  assign peak_next = (stereo_sel && !frame.right_sample[SAMPLE_W-1] &&
                      frame.right_sample[PEAK_W-1:0] > peak_l) ?
                     frame.right_sample[PEAK_W-1:0] : peak_l;

  assign left_abs  = item.left_sample[SAMPLE_W-1] ?
                     SAMPLE_W'(~item.left_sample + 1'b1) : SAMPLE_W'(item.left_sample);
  assign right_abs = item.right_sample[SAMPLE_W-1] ?
                     SAMPLE_W'(~item.right_sample + 1'b1) : SAMPLE_W'(item.right_sample);

  assign epeak_next = (ep > energy_peak) ? ep : energy_peak;

  always_comb begin
    case (state)
      S_SQL: begin
        mul_a = left_abs;
        mul_b = GAIN_W'(left_abs);
      end
      S_SQR: begin
        mul_a = right_abs;
        mul_b = GAIN_W'(right_abs);
      end
      S_VUL: begin
        mul_a = lrms;
        mul_b = VU_GAIN;
      end
      S_VUR: begin
        mul_a = rrms;
        mul_b = VU_GAIN;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign div_start    = (state == S_DIVL) || (state == S_DIVR) || (state == S_DIVE);
  assign div_divisor  = (frames_seen == '0) ? CNT_W'(1) : frames_seen;
  assign sqrt_start   = (state == S_SQRTL) || (state == S_SQRTR);
  assign div_waiting  = (state == S_WDIVL) || (state == S_WDIVR) || (state == S_WDIVE);
  assign sqrt_waiting = (state == S_WSQRTL) || (state == S_WSQRTR);

  always_comb begin
    case (state)
      S_DIVR:  div_dividend = right_sum;
      S_DIVE:  div_dividend = SUM_W'({lrms, 9'b0});
      default: div_dividend = left_sum;
    endcase
  end

  arpm_div #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  arpm_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand ({1'b0, mean}),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (frame_valid) state_next = S_SQL;
      S_SQL:    state_next = S_SQR;
      S_SQR:    state_next = S_ACCR;
      S_ACCR:   state_next = item.last_frame ? S_DIVL : S_IDLE;
      S_DIVL:   state_next = S_WDIVL;
      S_WDIVL:  if (div_done) state_next = S_SQRTL;
      S_SQRTL:  state_next = S_WSQRTL;
      S_WSQRTL: if (sqrt_done) state_next = S_DIVR;
      S_DIVR:   state_next = S_WDIVR;
      S_WDIVR:  if (div_done) state_next = S_SQRTR;
      S_SQRTR:  state_next = S_WSQRTR;
      S_WSQRTR: if (sqrt_done) state_next = S_DIVE;
      S_DIVE:   state_next = S_WDIVE;
      S_WDIVE:  if (div_done) state_next = S_VUL;
      S_VUL:    state_next = S_VUR;
      S_VUR:    state_next = S_FIN;
      S_FIN:    if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      stereo_sel   <= 1'b1;
      left_sum     <= '0;
      right_sum    <= '0;
      frames_seen  <= '0;
      running_peak <= '0;
      energy_peak  <= '0;
      level_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        stereo_sel <= stereo_mode;
      end
      if (state == S_FIN && out_free) begin
        level_valid <= 1'b1;
      end else if (!level_stall) begin
        level_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            running_peak <= peak_next;
            if (frame.restart) begin
              energy_peak <= '0;
            end
          end
        end
        S_SQR: begin
          if (counting) begin
            left_sum <= left_sum + SUM_W'(prod);
          end
        end
        S_ACCR: begin
          if (counting) begin
            if (item_stereo) begin
              right_sum <= right_sum + SUM_W'(prod);
            end
            frames_seen <= CNT_W'(frames_seen + 1'b1);
          end
        end
        S_FIN: begin
          if (out_free) begin
            energy_peak <= epeak_next;
            left_sum    <= '0;
            right_sum   <= '0;
            frames_seen <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item        <= frame;
      item_stereo <= stereo_sel;
    end
    if (state == S_SQL || state == S_SQR || state == S_VUL || state == S_VUR) begin
      prod <= mul_a * mul_b;
    end
    if (state == S_WDIVL || state == S_WDIVR) begin
      mean <= div_quotient[MEAN_W-1:0];
    end
    if (state == S_WDIVE) begin
      ep <= div_quotient[EPEAK_W-1:0];
    end
    if (state == S_WSQRTL) begin
      lrms <= sqrt_root;
    end
    if (state == S_WSQRTR) begin
      rrms <= sqrt_root;
    end
    if (state == S_VUR) begin
      left_lvl <= vu_round(prod);
    end
    if (state == S_FIN && out_free) begin
      level.left_level  <= left_lvl;
      level.right_level <= item_stereo ? vu_round(prod) : '0;
      level.peak_sample <= running_peak;
      level.energy_peak <= epeak_next;
    end
  end

  `ARPM_ASSERT_NEXT(a_accept_starts, clk, rst, accept, state == S_SQL)
  `ARPM_ASSERT_ALWAYS(a_frames_bound, clk, rst, frames_seen <= CNT_W'(MAX_FRAMES))
  `ARPM_ASSERT_SAME(a_div_done_waited, clk, rst, div_done, div_waiting)
  `ARPM_ASSERT_SAME(a_sqrt_done_waited, clk, rst, sqrt_done, sqrt_waiting)
  `ARPM_ASSERT_NEXT(a_epeak_holds, clk, rst, !(accept && frame.restart), energy_peak >= $past(energy_peak))

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
// Self-checking testbench for audio_rms_peak_meter: a directed table of frames, then random
// blocks, with every result beat compared to the table's typed value or an in-bench level model.
// Depends on arpm_pkg and the audio_rms_peak_meter RTL only.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import arpm_pkg::*;

  localparam int BLOCK_MAX    = 4096;
  localparam int DRAIN_CYCLES = 250;
  localparam int RANDOM_ITEMS = 1750;
  localparam int NUM_ROWS     = 17;

  typedef struct {
    bit     mode;
    frame_t f;
    bit     typed;
    level_t lv;
  } row_t;

  logic   clk = 1'b0;
  logic   rst;
  logic   frame_valid;
  logic   frame_stall;
  frame_t frame;
  logic   level_valid;
  logic   level_stall = 1'b0;
  level_t level;
  logic   cfg_valid;
  logic   cfg_ready;
  logic   stereo_mode;

  bit                 mode_q = 1'b1;
  longint unsigned    left_sum = 0;
  longint unsigned    right_sum = 0;
  int unsigned        frame_count = 0;
  logic [PEAK_W-1:0]  peak_model = '0;
  logic [EPEAK_W-1:0] energy_peak_q = '0;

  level_t pending_levels[$];
  int     errors = 0;
  int     items_sent = 0;
  int     burst_left = 0;
  int     stall_left = 0;
  int     stall_kind = 0;

  row_t directed_rows [NUM_ROWS] = '{
    '{1'b1, '{16'sd0, 16'sd0, 1'b1, 1'b1}, 1'b1, '{16'd0, 16'd0, 15'd0, 25'd0}},
    '{1'b1, '{-16'sd32768, -16'sd32768, 1'b1, 1'b1}, 1'b1,
      '{16'd58983, 16'd58983, 15'd0, 25'd16777216}},
    '{1'b1, '{16'sd32767, -16'sd32768, 1'b0, 1'b1}, 1'b0, '{default: '0}},
    '{1'b1, '{-16'sd1, 16'sd32767, 1'b1, 1'b0}, 1'b0, '{default: '0}},
    '{1'b1, '{16'sd1, -16'sd1, 1'b0, 1'b0}, 1'b0, '{default: '0}},
    '{1'b1, '{16'sd100, 16'sd200, 1'b0, 1'b0}, 1'b0, '{default: '0}},
    '{1'b1, '{-16'sd300, 16'sd5, 1'b1, 1'b0}, 1'b0, '{default: '0}},
    '{1'b0, '{16'sd1234, 16'sd32767, 1'b1, 1'b1}, 1'b0, '{default: '0}},
    '{1'b0, '{-16'sd32768, -16'sd32768, 1'b1, 1'b1}, 1'b1,
      '{16'd58983, 16'd0, 15'd0, 25'd16777216}},
    '{1'b0, '{16'sd5000, 16'sd7000, 1'b0, 1'b0}, 1'b0, '{default: '0}},
    '{1'b1, '{-16'sd5000, -16'sd7000, 1'b0, 1'b0}, 1'b0, '{default: '0}},
    '{1'b1, '{16'sd32767, 16'sd32767, 1'b1, 1'b0}, 1'b0, '{default: '0}},
    '{1'b1, '{16'sh5555, 16'shAAAA, 1'b0, 1'b0}, 1'b0, '{default: '0}},
    '{1'b1, '{16'shAAAA, 16'sh5555, 1'b1, 1'b0}, 1'b0, '{default: '0}},
    '{1'b0, '{16'sd7, -16'sd7, 1'b1, 1'b0}, 1'b0, '{default: '0}},
    '{1'b1, '{16'sd32767, 16'sd0, 1'b0, 1'b1}, 1'b0, '{default: '0}},
    '{1'b1, '{16'sd0, 16'sd32767, 1'b1, 1'b0}, 1'b0, '{default: '0}}
  };

  audio_rms_peak_meter #(
    .MAX_FRAMES(BLOCK_MAX)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .frame_valid(frame_valid),
    .frame_stall(frame_stall),
    .frame      (frame),
    .level_valid(level_valid),
    .level_stall(level_stall),
    .level      (level),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .stereo_mode(stereo_mode)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [15:0] int_root(longint unsigned v);
    logic [16:0] r;
    logic [16:0] t;
    r = '0;
    for (int b = 15; b >= 0; b--) begin
      t = r | (17'd1 << b);
      if (longint'(t) * longint'(t) <= v) begin
        r = t;
      end
    end
    return r[15:0];
  endfunction

  function automatic logic [LEVEL_W-1:0] vu_of(logic [15:0] rms);
    logic [33:0] p;
    p = 34'(rms) * 34'(VU_GAIN) + 34'd32768;
    return p[31:16];
  endfunction

  function automatic void account_frame(input frame_t f, output bit done, output level_t lv);
    int          l;
    int          r;
    logic [15:0] lrms;
    logic [15:0] rrms;
    longint      ep;
    l = f.left_sample;
    r = f.right_sample;
    done = 1'b0;
    lv = '0;
    if (f.restart) begin
      peak_model = '0;
      energy_peak_q = '0;
    end
    if (l > 0 && l > int'(peak_model)) begin
      peak_model = l[PEAK_W-1:0];
    end
    if (mode_q && r > 0 && r > int'(peak_model)) begin
      peak_model = r[PEAK_W-1:0];
    end
    if (frame_count < BLOCK_MAX) begin
      left_sum += longint'(l) * longint'(l);
      if (mode_q) begin
        right_sum += longint'(r) * longint'(r);
      end
      frame_count++;
    end
    if (f.last_frame) begin
      lrms = int_root(left_sum / frame_count);
      rrms = int_root(right_sum / frame_count);
      ep = (longint'(lrms) << 9) / frame_count;
      if (ep > longint'(energy_peak_q)) begin
        energy_peak_q = ep[EPEAK_W-1:0];
      end
      lv.left_level = vu_of(lrms);
      lv.right_level = mode_q ? vu_of(rrms) : '0;
      lv.peak_sample = peak_model;
      lv.energy_peak = energy_peak_q;
      done = 1'b1;
      left_sum = 0;
      right_sum = 0;
      frame_count = 0;
    end
  endfunction

  function automatic logic signed [15:0] pick_sample();
    case ($urandom_range(0, 5))
      0, 1: return 16'($urandom);
      2: begin
        case ($urandom_range(0, 4))
          0: return 16'sd32767;
          1: return -16'sd32768;
          2: return 16'sd0;
          3: return -16'sd1;
          default: return 16'sd1;
        endcase
      end
      3: return 16'($urandom_range(0, 128) - 64);
      default: return 16'($urandom_range(0, 4095) - 2048);
    endcase
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Entered and left just after a falling edge; valid stays high on return.
  task automatic send_frame(frame_t f, bit typed, level_t typed_lv);
    bit     done;
    level_t lv;
    frame <= f;
    frame_valid <= 1'b1;
    do @(posedge clk); while (frame_stall);
    account_frame(f, done, lv);
    if (done) begin
      pending_levels.push_back(typed ? typed_lv : lv);
    end
    items_sent++;
    @(negedge clk);
  endtask

  task automatic pace();
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        frame_valid <= 1'b0;
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
  endtask

  task automatic wait_idle();
    frame_valid <= 1'b0;
    while (pending_levels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_mode(bit m);
    wait_idle();
    cfg_valid <= 1'b1;
    stereo_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    mode_q = m;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_kind = $urandom_range(0, 2);
      stall_left = $urandom_range(50, 600);
    end
    stall_left--;
    case (stall_kind)
      0: level_stall <= 1'b0;
      1: level_stall <= ($urandom_range(0, 7) == 0);
      default: level_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    level_t want;
    if (!rst && level_valid && !level_stall) begin
      if (pending_levels.size() == 0) begin
        errors++;
        $display("%0t: level beat with no result pending, actual %p", $time, level);
      end else begin
        want = pending_levels.pop_front();
        check_field("left_level", want.left_level, level.left_level);
        check_field("right_level", want.right_level, level.right_level);
        check_field("peak_sample", want.peak_sample, level.peak_sample);
        check_field("energy_peak", want.energy_peak, level.energy_peak);
      end
    end
  end

  initial begin
    frame_t f;
    int     target;
    int     phase_end;
    int     len;
    bit     noisy;
    rst = 1'b1;
    frame_valid = 1'b0;
    frame = '0;
    cfg_valid = 1'b0;
    stereo_mode = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) begin
      if (directed_rows[k].mode != mode_q) begin
        set_mode(directed_rows[k].mode);
      end
      pace();
      send_frame(directed_rows[k].f, directed_rows[k].typed, directed_rows[k].lv);
    end

    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      set_mode($urandom_range(0, 1));
      phase_end = items_sent + $urandom_range(80, 300);
      while (items_sent < phase_end && items_sent < target) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
        noisy = ($urandom_range(0, 15) == 0);
        for (int i = 0; i < len && items_sent < phase_end; i++) begin
          f.left_sample = pick_sample();
          f.right_sample = pick_sample();
          f.last_frame = noisy ? 1'($urandom_range(0, 1)) : (i == len - 1);
          f.restart = ($urandom_range(0, 9) == 0);
          pace();
          send_frame(f, 1'b0, '0);
        end
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("audio_rms_peak_meter test passed");
    end else begin
      $display("audio_rms_peak_meter test failed");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("audio_rms_peak_meter test failed");
    $finish;
  end

endmodule

`default_nettype wire
